### src/rtwt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtwt_pkg
// Shared types and constants of the retry timer work table.
// ----------------------------------------------------------------------------
package rtwt_pkg;

	localparam int DEF_TABLE_SLOTS = 16;

	localparam logic [7:0] RETRY_INF = 8'hFF;

	typedef enum logic [2:0] {
		OP_REGISTER   = 3'd0,
		OP_UNREGISTER = 3'd1,
		OP_CHECK      = 3'd2,
		OP_REFRESH    = 3'd3,
		OP_RESET      = 3'd4,
		OP_CLEAR_ALL  = 3'd5,
		OP_TICK_HEAD  = 3'd6,
		OP_TICK_ALL   = 3'd7
	} op_t;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_FULL      = 2'd1;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

	typedef struct packed {
		op_t         op;
		logic [15:0] handler;
		logic [31:0] param;
		logic [31:0] period;
		logic [7:0]  retry;
		logic        fail;
		logic        sexp;
		logic [31:0] ticks;
	} cmd_t;

	typedef struct packed {
		logic [15:0] handler;
		logic [31:0] param;
		logic [31:0] period;
		logic [31:0] elapsed;
		logic [7:0]  retries;
		logic        fail;
	} entry_t;

	typedef struct packed {
		logic [15:0] handler;
		logic [31:0] param;
		logic        exhausted;
		logic        call_fail;
	} fire_t;

endpackage

### src/rtwt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtwt_front
// Accepts command items, decodes them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module rtwt_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [127:0]         s_axis_tdata,
	input  logic [2:0]           s_axis_tuser,
	output logic                 q_valid,
	output rtwt_pkg::cmd_t       q_data,
	input  logic                 q_pop
);

	rtwt_pkg::cmd_t qd_q [2];
	logic [1:0]     qn_q;
	rtwt_pkg::cmd_t dec;
	logic           push;
	logic           pop;
	logic           wa;

	always_comb begin
		dec.op      = rtwt_pkg::op_t'(s_axis_tuser);
		dec.handler = s_axis_tdata[15:0];
		dec.param   = s_axis_tdata[47:16];
		dec.period  = s_axis_tdata[79:48];
		dec.retry   = s_axis_tdata[87:80];
		dec.fail    = s_axis_tdata[88];
		dec.sexp    = s_axis_tdata[89];
		dec.ticks   = s_axis_tdata[121:90];
	end

	assign s_axis_tready = (qn_q != 2'd2);
	assign push          = s_axis_tvalid && s_axis_tready;
	assign pop           = q_pop && (qn_q != 2'd0);
	assign wa            = qn_q[1] || (qn_q[0] && !pop);
	assign q_valid       = (qn_q != 2'd0);
	assign q_data        = qd_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qn_q <= 2'd0;
		end else begin
			qn_q <= qn_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push && !wa) begin
			qd_q[0] <= dec;
		end else if (pop) begin
			qd_q[0] <= qd_q[1];
		end
		if (push && wa) begin
			qd_q[1] <= dec;
		end
	end

endmodule

### src/rtwt_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtwt_engine
// Job table, command sequencer, fire buffer and result register.
// ----------------------------------------------------------------------------
module rtwt_engine #(
	parameter int TABLE_SLOTS = rtwt_pkg::DEF_TABLE_SLOTS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  rtwt_pkg::cmd_t q_data,
	output logic           q_pop,
	output logic           m_axis_tvalid,
	input  logic           m_axis_tready,
	output logic [63:0]    m_axis_tdata,
	output logic           m_axis_tuser,
	output logic           m_axis_tlast
);

	localparam int CW = $clog2(TABLE_SLOTS + 1);
	localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FIND,
		S_ADD,
		S_CHK,
		S_DRAIN
	} state_t;

	state_t             state_q;
	rtwt_pkg::cmd_t     cur_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      idx_q;
	logic [CW-1:0]      fb_cnt_q;
	logic [1:0]         status_q;
	logic [31:0]        sum_q;
	logic               m_valid_q;
	logic [63:0]        m_data_q;
	logic               m_user_q;
	logic               m_last_q;

	rtwt_pkg::entry_t   tbl_q [TABLE_SLOTS];
	rtwt_pkg::fire_t    fb_q  [TABLE_SLOTS];

	rtwt_pkg::entry_t   rd;
	logic               in_range;
	logic               match;
	logic               out_free;
	logic [32:0]        add;
	logic [31:0]        sat;
	logic               fire;
	logic               gone;

	logic               tbl_wr;
	logic               tbl_rm;
	logic [IW-1:0]      tbl_wa;
	rtwt_pkg::entry_t   tbl_wd;
	logic               fb_push;
	logic               fb_pop;
	rtwt_pkg::fire_t    fb_wd;

	assign rd       = tbl_q[idx_q[IW-1:0]];
	assign in_range = (idx_q < count_q);
	assign match    = (rd.handler == cur_q.handler);
	assign out_free = !m_valid_q || m_axis_tready;
	assign add      = {1'b0, rd.elapsed} + {1'b0, cur_q.ticks};
	assign sat      = add[32] ? 32'hFFFF_FFFF : add[31:0];
	assign fire     = (sum_q > rd.period);
	assign gone     = (rd.retries != rtwt_pkg::RETRY_INF) && (rd.retries <= 8'd1);
	assign q_pop    = (state_q == S_IDLE) && q_valid;

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;
	assign m_axis_tlast  = m_last_q;

	always_comb begin
		tbl_wr  = 1'b0;
		tbl_rm  = 1'b0;
		tbl_wa  = idx_q[IW-1:0];
		tbl_wd  = rd;
		fb_push = 1'b0;
		fb_pop  = 1'b0;
		fb_wd.handler   = rd.handler;
		fb_wd.param     = rd.param;
		fb_wd.exhausted = gone;
		fb_wd.call_fail = gone && rd.fail;
		case (state_q)
			S_IDLE: begin
				if (q_valid && q_data.op == rtwt_pkg::OP_REGISTER
						&& count_q < CW'(TABLE_SLOTS)) begin
					tbl_wr         = 1'b1;
					tbl_wa         = count_q[IW-1:0];
					tbl_wd.handler = q_data.handler;
					tbl_wd.param   = q_data.param;
					tbl_wd.period  = q_data.period;
					tbl_wd.elapsed = q_data.sexp ? q_data.period : 32'd0;
					tbl_wd.retries = q_data.retry;
					tbl_wd.fail    = q_data.fail;
				end
			end
			S_FIND: begin
				if (in_range && match) begin
					case (cur_q.op)
						rtwt_pkg::OP_UNREGISTER: tbl_rm = 1'b1;
						rtwt_pkg::OP_REFRESH: begin
							tbl_wr         = 1'b1;
							tbl_wd.elapsed = rd.period;
						end
						rtwt_pkg::OP_RESET: begin
							tbl_wr         = 1'b1;
							tbl_wd.elapsed = 32'd0;
						end
						default: ;
					endcase
				end
			end
			S_CHK: begin
				if (!fire) begin
					tbl_wr         = 1'b1;
					tbl_wd.elapsed = sum_q;
				end else begin
					fb_push = 1'b1;
					if (gone) begin
						tbl_rm = 1'b1;
					end else begin
						tbl_wr         = 1'b1;
						tbl_wd.elapsed = 32'd0;
						if (rd.retries != rtwt_pkg::RETRY_INF) begin
							tbl_wd.retries = rd.retries - 8'd1;
						end
					end
				end
			end
			S_DRAIN: fb_pop = (fb_cnt_q != '0) && out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (tbl_rm) begin
			for (int j = 0; j < TABLE_SLOTS - 1; j++) begin
				if (IW'(j) >= tbl_wa) begin
					tbl_q[j] <= tbl_q[j + 1];
				end
			end
		end else if (tbl_wr) begin
			tbl_q[tbl_wa] <= tbl_wd;
		end
		if (fb_pop) begin
			for (int j = 0; j < TABLE_SLOTS - 1; j++) begin
				fb_q[j] <= fb_q[j + 1];
			end
		end else if (fb_push) begin
			fb_q[fb_cnt_q[IW-1:0]] <= fb_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cur_q     <= '0;
			count_q   <= '0;
			idx_q     <= '0;
			fb_cnt_q  <= '0;
			status_q  <= rtwt_pkg::STAT_OK;
			sum_q     <= '0;
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
			m_user_q  <= 1'b0;
			m_last_q  <= 1'b0;
		end else begin
			if (m_axis_tready && state_q != S_DRAIN) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						cur_q    <= q_data;
						idx_q    <= '0;
						status_q <= rtwt_pkg::STAT_OK;
						case (q_data.op)
							rtwt_pkg::OP_REGISTER: begin
								if (count_q >= CW'(TABLE_SLOTS)) begin
									status_q <= rtwt_pkg::STAT_FULL;
								end else begin
									count_q <= count_q + 1'b1;
								end
								state_q <= S_DRAIN;
							end
							rtwt_pkg::OP_CLEAR_ALL: begin
								count_q <= '0;
								state_q <= S_DRAIN;
							end
							rtwt_pkg::OP_TICK_HEAD, rtwt_pkg::OP_TICK_ALL: begin
								if (count_q != '0 && q_data.ticks != 32'd0) begin
									state_q <= S_ADD;
								end else begin
									state_q <= S_DRAIN;
								end
							end
							default: state_q <= S_FIND;
						endcase
					end
				end
				S_FIND: begin
					if (!in_range) begin
						status_q <= rtwt_pkg::STAT_NOT_FOUND;
						state_q  <= S_DRAIN;
					end else if (match) begin
						if (cur_q.op == rtwt_pkg::OP_UNREGISTER) begin
							count_q <= count_q - 1'b1;
						end
						state_q <= S_DRAIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_ADD: begin
					if (!in_range) begin
						state_q <= S_DRAIN;
					end else begin
						sum_q   <= sat;
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (fire) begin
						fb_cnt_q <= fb_cnt_q + 1'b1;
						if (gone) begin
							count_q <= count_q - 1'b1;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end else begin
						idx_q <= idx_q + 1'b1;
					end
					state_q <= (cur_q.op == rtwt_pkg::OP_TICK_HEAD) ? S_DRAIN : S_ADD;
				end
				S_DRAIN: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						if (fb_cnt_q != '0) begin
							fb_cnt_q <= fb_cnt_q - 1'b1;
							m_data_q <= {6'd0, 6'(count_q), rtwt_pkg::STAT_OK,
								fb_q[0].call_fail, fb_q[0].exhausted,
								fb_q[0].param, fb_q[0].handler};
							m_user_q <= 1'b0;
							m_last_q <= 1'b0;
						end else begin
							m_data_q <= {6'd0, 6'(count_q), status_q, 2'b00,
								32'd0, 16'd0};
							m_user_q <= 1'b1;
							m_last_q <= 1'b1;
							state_q  <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### src/retry_timer_work_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// retry_timer_work_table
// Ordered table of periodic jobs with retry counts and fail flags.
// ----------------------------------------------------------------------------
// Usage:
//   Command items enter on s_axis (command in tuser); each command returns
//   zero or more fire items (tuser 0) and one status item (tuser 1, tlast 1)
//   on m_axis. entry_count in every item is the job count after the command.
//   A two-entry command queue sits in front of the sequencer, so new items
//   are taken while the previous command is still at work.
//   Register, clear_all and tick commands on an empty table or with zero
//   ticks go straight to the status item; unregister, check, refresh and
//   reset compare one slot at a time until the handler matches; tick_head
//   visits the head slot and tick_all every slot, each in two steps (add,
//   then compare and update).
//   The sequencer takes the next queued command the cycle after the status.
//   Reset empties the table and the queue and drops any pending result.
//   A stalled receiver holds the result register; the sequencer waits in its
//   drain phase and the queue fills, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module retry_timer_work_table #(
	parameter int TABLE_SLOTS = rtwt_pkg::DEF_TABLE_SLOTS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// handler_id, job_param, period, retry_limit, has_fail_routine,
	// start_expired, elapsed_ticks
	input  logic [127:0] s_axis_tdata,
	// command
	input  logic [2:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// fired_handler, fired_param, exhausted, call_fail, status, entry_count
	output logic [63:0]  m_axis_tdata,
	// kind
	output logic         m_axis_tuser,
	output logic         m_axis_tlast
);

	logic           q_valid;
	logic           q_pop;
	rtwt_pkg::cmd_t q_data;

	rtwt_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_valid       (q_valid),
		.q_data        (q_data),
		.q_pop         (q_pop)
	);

	rtwt_engine #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_data        (q_data),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the retry timer work table.
// Commands go in on the slave stream. A model of the job table in the
// scoreboard predicts the fire and status items of each accepted command.
// Each item leaving on the master stream is checked field by field against
// the oldest prediction. Both sides idle at random, with one long receiver
// hold-off and one sender pause after all expected items have come out.
// ----------------------------------------------------------------------------
typedef struct packed {
	logic        kind;
	logic [15:0] handler;
	logic [31:0] param;
	logic        exhausted;
	logic        call_fail;
	logic [1:0]  status;
	logic [5:0]  count;
	logic        last;
} job_result_t;

class job_table_sb;
	rtwt_pkg::entry_t slots[rtwt_pkg::DEF_TABLE_SLOTS];
	int          jobs;
	job_result_t pending[$];
	int          errors;

	function new();
		jobs = 0;
		errors = 0;
	endfunction

	function void report(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t: mismatch %s: got %0h want %0h", $realtime, what, got, want);
		errors++;
	endfunction

	function void drop_slot(int idx);
		for (int i = idx; i + 1 < jobs; i++)
			slots[i] = slots[i + 1];
		jobs--;
	endfunction

	// returns 1 if the job ran out of retries
	function bit advance_slot(int i, logic [31:0] ticks, ref job_result_t fires[$]);
		job_result_t r;
		logic [32:0] sum;
		bit gone;
		sum = slots[i].elapsed + ticks;
		slots[i].elapsed = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
		if (slots[i].elapsed <= slots[i].period)
			return 0;
		slots[i].elapsed = 0;
		gone = 0;
		if (slots[i].retries != rtwt_pkg::RETRY_INF) begin
			if (slots[i].retries <= 1) begin
				slots[i].retries = 0;
				gone = 1;
			end else begin
				slots[i].retries--;
			end
		end
		r = '0;
		r.handler = slots[i].handler;
		r.param = slots[i].param;
		r.exhausted = gone;
		r.call_fail = gone & slots[i].fail;
		fires.push_back(r);
		return gone;
	endfunction

	function void note_command(rtwt_pkg::cmd_t c);
		job_result_t fires[$];
		job_result_t st;
		int idx;
		st = '0;
		st.kind = 1;
		st.last = 1;
		case (c.op)
			rtwt_pkg::OP_REGISTER: begin
				if (jobs >= rtwt_pkg::DEF_TABLE_SLOTS) begin
					st.status = rtwt_pkg::STAT_FULL;
				end else begin
					slots[jobs].handler = c.handler;
					slots[jobs].param = c.param;
					slots[jobs].period = c.period;
					slots[jobs].elapsed = c.sexp ? c.period : 32'd0;
					slots[jobs].retries = c.retry;
					slots[jobs].fail = c.fail;
					jobs++;
				end
			end
			rtwt_pkg::OP_UNREGISTER, rtwt_pkg::OP_CHECK, rtwt_pkg::OP_REFRESH,
			rtwt_pkg::OP_RESET: begin
				idx = -1;
				for (int i = 0; i < jobs; i++)
					if (idx < 0 && slots[i].handler == c.handler)
						idx = i;
				if (idx < 0)
					st.status = rtwt_pkg::STAT_NOT_FOUND;
				else if (c.op == rtwt_pkg::OP_UNREGISTER)
					drop_slot(idx);
				else if (c.op == rtwt_pkg::OP_REFRESH)
					slots[idx].elapsed = slots[idx].period;
				else if (c.op == rtwt_pkg::OP_RESET)
					slots[idx].elapsed = 0;
			end
			rtwt_pkg::OP_CLEAR_ALL: jobs = 0;
			rtwt_pkg::OP_TICK_HEAD: begin
				if (jobs > 0 && c.ticks != 0)
					if (advance_slot(0, c.ticks, fires))
						drop_slot(0);
			end
			default: begin
				if (jobs > 0 && c.ticks != 0) begin
					idx = 0;
					while (idx < jobs) begin
						if (advance_slot(idx, c.ticks, fires))
							drop_slot(idx);
						else
							idx++;
					end
				end
			end
		endcase
		fires.push_back(st);
		foreach (fires[k]) begin
			fires[k].count = jobs[5:0];
			pending.push_back(fires[k]);
		end
	endfunction

	function void check_result(logic [63:0] data, logic user, logic tlast);
		job_result_t w;
		if (pending.size() == 0) begin
			report("unexpected item", data, 0);
			return;
		end
		w = pending.pop_front();
		if (user != w.kind)           report("kind", user, w.kind);
		if (data[15:0] != w.handler)  report("fired_handler", data[15:0], w.handler);
		if (data[47:16] != w.param)   report("fired_param", data[47:16], w.param);
		if (data[48] != w.exhausted)  report("exhausted", data[48], w.exhausted);
		if (data[49] != w.call_fail)  report("call_fail", data[49], w.call_fail);
		if (data[51:50] != w.status)  report("status", data[51:50], w.status);
		if (data[57:52] != w.count)   report("entry_count", data[57:52], w.count);
		if (data[63:58] != 0)         report("padding", data[63:58], 0);
		if (tlast != w.last)          report("last", tlast, w.last);
	endfunction
endclass

module tb;
	localparam int WATCHDOG_LIMIT = 3000;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata;
	logic [2:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [63:0]  m_axis_tdata;
	logic         m_axis_tuser;
	logic         m_axis_tlast;

	job_table_sb sb;
	bit          calm;
	bit          hold_req;
	int          hold_left = 0;
	int          idle_cycles = 0;
	int          sent;

	retry_timer_work_table uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	initial clk = 0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
	end

	// receiver: random stalls, plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_req && hold_left == 0) begin
			hold_left = 400;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready = 0;
		end else begin
			m_axis_tready = calm || ($urandom_range(99) >= 12);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send_cmd(rtwt_pkg::cmd_t c);
		if (!calm)
			while ($urandom_range(99) < 12) begin
				s_axis_tvalid = 0;
				@(negedge clk);
			end
		s_axis_tvalid = 1;
		s_axis_tuser = c.op;
		s_axis_tdata = {6'd0, c.ticks, c.sexp, c.fail, c.retry, c.period, c.param, c.handler};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_command(c);
		sent++;
		@(negedge clk);
		s_axis_tvalid = 0;
	endtask

	task automatic run_cmd(rtwt_pkg::op_t op, logic [15:0] h, logic [31:0] param,
			logic [31:0] period, logic [7:0] retry, logic fail, logic sexp,
			logic [31:0] ticks);
		rtwt_pkg::cmd_t c;
		c.op = op;
		c.handler = h;
		c.param = param;
		c.period = period;
		c.retry = retry;
		c.fail = fail;
		c.sexp = sexp;
		c.ticks = ticks;
		send_cmd(c);
	endtask

	task automatic send_random();
		rtwt_pkg::cmd_t c;
		int pick;
		bit wide;
		wide = ($urandom_range(9) == 0);
		pick = $urandom_range(99);
		if (pick < 30)      c.op = rtwt_pkg::OP_REGISTER;
		else if (pick < 38) c.op = rtwt_pkg::OP_UNREGISTER;
		else if (pick < 44) c.op = rtwt_pkg::OP_CHECK;
		else if (pick < 50) c.op = rtwt_pkg::OP_REFRESH;
		else if (pick < 56) c.op = rtwt_pkg::OP_RESET;
		else if (pick < 59) c.op = rtwt_pkg::OP_CLEAR_ALL;
		else if (pick < 72) c.op = rtwt_pkg::OP_TICK_HEAD;
		else                c.op = rtwt_pkg::OP_TICK_ALL;
		c.handler = wide ? 16'($urandom) : 16'($urandom_range(7));
		c.param = $urandom;
		c.period = wide ? $urandom : $urandom_range(20);
		pick = $urandom_range(9);
		c.retry = (pick < 2) ? rtwt_pkg::RETRY_INF :
			(pick == 2) ? 8'($urandom) : 8'($urandom_range(4));
		c.fail = 1'($urandom_range(1));
		c.sexp = 1'($urandom_range(1));
		c.ticks = wide ? $urandom : $urandom_range(12);
		send_cmd(c);
	endtask

	task automatic wait_drained();
		while (sb.pending.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		sb = new();
		calm = 0;
		hold_req = 0;
		sent = 0;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tuser = rtwt_pkg::OP_REGISTER;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// empty table
		run_cmd(rtwt_pkg::OP_TICK_ALL, 0, 0, 0, 0, 0, 0, 32'd5);
		run_cmd(rtwt_pkg::OP_TICK_HEAD, 0, 0, 0, 0, 0, 0, 32'd5);
		run_cmd(rtwt_pkg::OP_CHECK, 16'hFFFF, 0, 0, 0, 0, 0, 0);
		// fill past capacity; duplicates and edge values
		for (int i = 0; i < 17; i++)
			run_cmd(rtwt_pkg::OP_REGISTER, (i % 3 == 0) ? 16'hFFFF : 16'(i),
				32'hFFFF_FFFF - i, (i == 1) ? 32'hFFFF_FFFF : 32'(i),
				(i < 4) ? 8'd0 : rtwt_pkg::RETRY_INF, i[0], i[1], 32'hFFFF_FFFF);
		run_cmd(rtwt_pkg::OP_TICK_ALL, 0, 0, 0, 0, 0, 0, 32'd0);
		run_cmd(rtwt_pkg::OP_TICK_HEAD, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
		run_cmd(rtwt_pkg::OP_TICK_ALL, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
		run_cmd(rtwt_pkg::OP_TICK_ALL, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
		run_cmd(rtwt_pkg::OP_REFRESH, 16'd5, 0, 0, 0, 0, 0, 0);
		run_cmd(rtwt_pkg::OP_RESET, 16'hFFFF, 0, 0, 0, 0, 0, 0);
		run_cmd(rtwt_pkg::OP_UNREGISTER, 16'hFFFF, 0, 0, 0, 0, 0, 0);
		run_cmd(rtwt_pkg::OP_UNREGISTER, 16'h1234, 0, 0, 0, 0, 0, 0);
		run_cmd(rtwt_pkg::OP_CLEAR_ALL, 0, 0, 0, 0, 0, 0, 0);

		for (int n = 0; n < 300; n++) begin
			calm = (n >= 200 && n < 260);
			if (n == 90) begin
				wait_drained();
				repeat (60) @(negedge clk);
			end
			if (n == 140)
				hold_req = 1;
			send_random();
		end
		calm = 0;

		wait_drained();
		repeat (60) @(negedge clk);
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

### filelist.f
src/rtwt_pkg.sv
src/rtwt_front.sv
src/rtwt_engine.sv
src/retry_timer_work_table.sv
test/tb.sv
